// ----- hdl/pcf_pkg.sv -----
package pcf_pkg;

   localparam int FRAME_BYTES         = 7;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int BYTE_IDX_W          = $clog2(FRAME_BYTES);

   localparam int ANGLE_W   = 17;
   localparam int PAN_OFF_W = 17;
   localparam int TILT_OFF_W = 15;
   localparam int READING_W = 18;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 17;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PAN_OFFSET  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_OFFSET = 1'b1;

   localparam logic [7:0] SYNC_BYTE      = 8'hFF;
   localparam logic [7:0] CMD_SET_PAN    = 8'h4B;
   localparam logic [7:0] CMD_SET_TILT   = 8'h4D;
   localparam logic [7:0] CMD_QUERY_PAN  = 8'h51;
   localparam logic [7:0] CMD_QUERY_TILT = 8'h53;
   localparam logic [7:0] CMD_PRESET_SET = 8'h03;
   localparam logic [7:0] CMD_PRESET_CLR = 8'h05;
   localparam logic [7:0] CMD_PRESET_GO  = 8'h07;

   // Angles in hundredths of a degree
   localparam int PAN_FULL_TURN = 36000;
   localparam int TILT_ZERO     = 9000;

   localparam int REPLY_HIGH_IDX = 4;
   localparam int REPLY_LOW_IDX  = 5;

   typedef enum logic [2:0] {
      OP_SET_PAN    = 3'd0,
      OP_SET_TILT   = 3'd1,
      OP_QUERY_PAN  = 3'd2,
      OP_QUERY_TILT = 3'd3,
      OP_PRESET_GO  = 3'd4,
      OP_PRESET_SET = 3'd5,
      OP_PRESET_CLR = 3'd6,
      OP_REPLY      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_PAN  = 2'd1,
      KIND_TILT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_PAN  = 2'd1,
      PEND_TILT = 2'd2
   } pending_type;

   typedef struct packed {
      logic                        is_frame;
      kind_type                    kind;
      logic [7:0]                  cmd;
      logic [7:0]                  data_hi;
      logic [7:0]                  data_lo;
      logic [7:0]                  checksum;
      logic signed [READING_W-1:0] reading;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hdl/pcf_front.sv -----
module pcf_front
   import pcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  accept,
   input  op_type                operation,
   input  logic [ANGLE_W-1:0]    angle_centi,
   input  logic [7:0]            preset_number,
   input  logic [7:0]            reply_byte,
   output logic                  push,
   output job_type               push_job
);

   logic [PAN_OFF_W-1:0]  pan_off_ff, pan_off_in;
   logic [TILT_OFF_W-1:0] tilt_off_ff, tilt_off_in;
   pending_type           pending_ff, pending_in;
   logic [2:0]            count_ff, count_in;
   logic [7:0]            high_ff, high_in;
   logic [7:0]            low_ff, low_in;

   logic signed [18:0]          pan_sum, pan_wrap, tilt_val;
   logic signed [17:0]          tilt_sum, raw_ext, raw_less_tilt;
   logic signed [READING_W-1:0] pan_reading, tilt_reading;
   logic [15:0]                 pan_u, tilt_u;
   logic                        reply_done;
   logic [7:0]                  cmd, d_hi, d_lo;

   function automatic logic [15:0] clamp16(input logic signed [18:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = 16'h0000;
      end else if (v > 19'sd65535) begin
         r = 16'hFFFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Set pan: add offset, wrap once into one turn, clamp
   always_comb begin
      pan_sum = $signed({{2{angle_centi[ANGLE_W-1]}}, angle_centi})
              + $signed({{2{pan_off_ff[PAN_OFF_W-1]}}, pan_off_ff});
      if (pan_sum < 0) begin
         pan_wrap = pan_sum + 19'(PAN_FULL_TURN);
      end else if (pan_sum >= 19'(PAN_FULL_TURN)) begin
         pan_wrap = pan_sum - 19'(PAN_FULL_TURN);
      end else begin
         pan_wrap = pan_sum;
      end
      pan_u = clamp16(pan_wrap);
   end

   // Set tilt: zero at horizon, mirrored
   always_comb begin
      tilt_sum = $signed({angle_centi[ANGLE_W-1], angle_centi})
               + $signed({{3{tilt_off_ff[TILT_OFF_W-1]}}, tilt_off_ff});
      tilt_val = 19'(TILT_ZERO) - $signed({tilt_sum[17], tilt_sum});
      tilt_u   = clamp16(tilt_val);
   end

   // Reading decode from the stored reply bytes
   always_comb begin
      raw_ext       = $signed({2'b00, high_ff, low_ff});
      pan_reading   = raw_ext - $signed({pan_off_ff[PAN_OFF_W-1], pan_off_ff});
      raw_less_tilt = raw_ext - $signed({{3{tilt_off_ff[TILT_OFF_W-1]}}, tilt_off_ff});
      tilt_reading  = 18'(TILT_ZERO) - raw_less_tilt;
   end

   always_comb begin
      cmd  = CMD_PRESET_CLR;
      d_hi = 8'h00;
      d_lo = preset_number;
      unique case (operation)
         OP_SET_PAN: begin
            cmd  = CMD_SET_PAN;
            d_hi = pan_u[15:8];
            d_lo = pan_u[7:0];
         end
         OP_SET_TILT: begin
            cmd  = CMD_SET_TILT;
            d_hi = tilt_u[15:8];
            d_lo = tilt_u[7:0];
         end
         OP_QUERY_PAN: begin
            cmd  = CMD_QUERY_PAN;
            d_lo = 8'h00;
         end
         OP_QUERY_TILT: begin
            cmd  = CMD_QUERY_TILT;
            d_lo = 8'h00;
         end
         OP_PRESET_GO:  cmd = CMD_PRESET_GO;
         OP_PRESET_SET: cmd = CMD_PRESET_SET;
         OP_PRESET_CLR: cmd = CMD_PRESET_CLR;
         OP_REPLY:      cmd = CMD_PRESET_CLR;
         default:       cmd = CMD_PRESET_CLR;
      endcase
   end

   assign reply_done = (operation == OP_REPLY) && (pending_ff != PEND_NONE)
                       && (count_ff == 3'(FRAME_BYTES - 1));

   always_comb begin
      push_job.is_frame = (operation != OP_REPLY);
      push_job.kind     = KIND_BYTE;
      push_job.cmd      = cmd;
      push_job.data_hi  = d_hi;
      push_job.data_lo  = d_lo;
      push_job.checksum = cmd + d_hi + d_lo;
      push_job.reading  = '0;
      if (operation == OP_REPLY) begin
         if (pending_ff == PEND_PAN) begin
            push_job.kind    = KIND_PAN;
            push_job.reading = pan_reading;
         end else begin
            push_job.kind    = KIND_TILT;
            push_job.reading = tilt_reading;
         end
      end
   end

   assign push = accept && ((operation != OP_REPLY) || reply_done);

   // Reply tracking and configuration
   always_comb begin
      pan_off_in  = pan_off_ff;
      tilt_off_in = tilt_off_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      if (csr_we) begin
         if (csr_index == CSR_PAN_OFFSET) begin
            pan_off_in = csr_wdata[PAN_OFF_W-1:0];
         end else begin
            tilt_off_in = csr_wdata[TILT_OFF_W-1:0];
         end
      end
      if (accept) begin
         if (operation == OP_REPLY) begin
            if (pending_ff != PEND_NONE) begin
               if (count_ff == 3'(REPLY_HIGH_IDX)) begin
                  high_in = reply_byte;
               end
               if (count_ff == 3'(REPLY_LOW_IDX)) begin
                  low_in = reply_byte;
               end
               if (reply_done) begin
                  pending_in = PEND_NONE;
                  count_in   = '0;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
         end else begin
            count_in = '0;
            if (operation == OP_QUERY_PAN) begin
               pending_in = PEND_PAN;
            end else if (operation == OP_QUERY_TILT) begin
               pending_in = PEND_TILT;
            end else begin
               pending_in = PEND_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_off_ff  <= '0;
         tilt_off_ff <= '0;
         pending_ff  <= PEND_NONE;
         count_ff    <= '0;
         high_ff     <= '0;
         low_ff      <= '0;
      end else begin
         pan_off_ff  <= pan_off_in;
         tilt_off_ff <= tilt_off_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         high_ff     <= high_in;
         low_ff      <= low_in;
      end
   end

`ifndef SYNTHESIS
   a_count_needs_query: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 3'd0) |-> (pending_ff != PEND_NONE))
      else $error("reply count running with no query pending");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < 3'(FRAME_BYTES))
      else $error("reply count past frame length");
`endif

endmodule

// ----- hdl/pcf_queue.sv -----
module pcf_queue
   import pcf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign status.full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? advance(wr_ff) : wr_ff;
      rd_in  = do_pop ? advance(rd_ff) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job pushed into a full queue");
`endif

endmodule

// ----- hdl/pcf_back.sv -----
module pcf_back
   import pcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  job_type               head_job,
   input  q_status_type          status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic                        valid_ff, valid_in;
   kind_type                    kind_ff, kind_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic signed [READING_W-1:0] reading_ff, reading_in;
   logic [BYTE_IDX_W-1:0]       idx_ff, idx_in;
   logic                        load, at_last;
   logic [7:0]                  frame_byte;

   assign load    = !valid_ff || rsp_tready;
   assign at_last = (idx_ff == BYTE_IDX_W'(FRAME_BYTES - 1));

   always_comb begin
      unique case (idx_ff)
         3'd0:    frame_byte = SYNC_BYTE;
         3'd3:    frame_byte = head_job.cmd;
         3'd4:    frame_byte = head_job.data_hi;
         3'd5:    frame_byte = head_job.data_lo;
         3'd6:    frame_byte = head_job.checksum;
         default: frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      reading_in = reading_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            if (head_job.is_frame) begin
               kind_in    = KIND_BYTE;
               byte_in    = frame_byte;
               last_in    = at_last;
               reading_in = '0;
               pop        = at_last;
               idx_in     = at_last ? '0 : idx_ff + BYTE_IDX_W'(1);
            end else begin
               kind_in    = head_job.kind;
               byte_in    = 8'h00;
               last_in    = 1'b0;
               reading_in = head_job.reading;
               pop        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      reading_ff <= reading_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'b000000, reading_ff, byte_ff};

`ifndef SYNTHESIS
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> (valid_ff && !last_ff && kind_ff == KIND_BYTE))
      else $error("frame counter running without a frame byte on the output");

   a_pop_only_on_load: assert property (@(posedge clock) disable iff (reset)
      pop |-> (load && !status.empty))
      else $error("job released without a word being loaded");
`endif

endmodule

// ----- hdl/ptz_pelco_command_framer_top.sv -----
// PTZ command framer. Each command word on req_ (set pan, set tilt, query
// pan, query tilt, preset call, set or clear) yields one seven-byte frame
// on rsp_: sync 0xFF, two zero bytes, command, two data bytes and the
// checksum of bytes four to six, one byte per word and tlast on the
// seventh. Pan angles take the pan offset and are wrapped once into one
// turn; tilt is sent as 9000 minus (angle plus tilt offset); both are
// clamped to 16 bits. After a query the next seven reply-byte words are
// counted and one reading word (tuser 1 pan, 2 tilt) follows the seventh;
// reply bytes with no query pending are dropped. The serialiser's byte
// counter walks the frame, sending one byte per cycle while rsp_tready
// is high. The front takes a new word every cycle while the job queue of
// QUEUE_DEPTH entries between front and serialiser has room, so it keeps
// accepting while a frame is still going out. Write the offsets on csr_
// only while no frame is in flight.
module ptz_pelco_command_framer_top
   import pcf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration: index 0 pan offset, 1 tilt offset
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: angle_centi[16:0], preset_number[24:17], reply_byte[32:25], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: operation[2:0]
   input  logic [2:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: send_byte[7:0], reading_centi[25:8], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: result_kind[1:0]
   output logic [1:0]             rsp_tuser,
   // tlast: frame_end
   output logic                   rsp_tlast
);

   logic         accept;
   logic         push, pop;
   job_type      push_job, head_job;
   q_status_type status;
   op_type       operation;

   // Hold off the source only when the job queue is full
   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;
   assign operation  = op_type'(req_tuser);

   pcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .operation     (operation),
      .angle_centi   (req_tdata[16:0]),
      .preset_number (req_tdata[24:17]),
      .reply_byte    (req_tdata[32:25]),
      .push          (push),
      .push_job      (push_job)
   );

   pcf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   pcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/sv/pcf_check_pkg.sv -----
package pcf_check_pkg;

   import pcf_pkg::*;

   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  data;
      logic                        last;
      logic signed [READING_W-1:0] reading;
   } framer_word_type;

   class ptz_frame_ledger;

      int              pan_offset;
      int              tilt_offset;
      pending_type     awaiting;
      int              reply_count;
      logic [7:0]      reply_hi;
      logic [7:0]      reply_lo;
      framer_word_type due_words[$];
      int              errors;
      int              frames;
      int              readings;

      function new();
         pan_offset  = 0;
         tilt_offset = 0;
         awaiting    = PEND_NONE;
         reply_count = 0;
         reply_hi    = '0;
         reply_lo    = '0;
         errors      = 0;
         frames      = 0;
         readings    = 0;
      endfunction

      function void set_offset(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_PAN_OFFSET) begin
            pan_offset = $signed(value[PAN_OFF_W-1:0]);
         end else begin
            tilt_offset = $signed(value[TILT_OFF_W-1:0]);
         end
      endfunction

      function int outstanding();
         return due_words.size();
      endfunction

      function int clamp16(int v);
         if (v < 0) begin
            return 0;
         end
         if (v > 65535) begin
            return 65535;
         end
         return v;
      endfunction

      function void push_frame(logic [7:0] cmd, logic [7:0] d1, logic [7:0] d2);
         logic [7:0]      bytes [FRAME_BYTES];
         framer_word_type w;
         bytes[0] = SYNC_BYTE;
         bytes[1] = 8'h00;
         bytes[2] = 8'h00;
         bytes[3] = cmd;
         bytes[4] = d1;
         bytes[5] = d2;
         bytes[6] = cmd + d1 + d2;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            w.kind    = KIND_BYTE;
            w.data    = bytes[i];
            w.last    = (i == FRAME_BYTES - 1);
            w.reading = '0;
            due_words.push_back(w);
         end
         frames++;
      endfunction

      // returns 0 when the word is dropped by the block
      function bit take_request(op_type op, int angle, logic [7:0] preset, logic [7:0] rbyte);
         int              v;
         int              raw;
         framer_word_type w;
         if (op == OP_REPLY) begin
            if (awaiting == PEND_NONE) begin
               return 1'b0;
            end
            if (reply_count == REPLY_HIGH_IDX) begin
               reply_hi = rbyte;
            end else if (reply_count == REPLY_LOW_IDX) begin
               reply_lo = rbyte;
            end
            reply_count++;
            if (reply_count < FRAME_BYTES) begin
               return 1'b1;
            end
            raw    = {16'h0000, reply_hi, reply_lo};
            w.data = 8'h00;
            w.last = 1'b0;
            if (awaiting == PEND_PAN) begin
               w.kind = KIND_PAN;
               v      = raw - pan_offset;
            end else begin
               w.kind = KIND_TILT;
               v      = TILT_ZERO - (raw - tilt_offset);
            end
            w.reading   = v[READING_W-1:0];
            awaiting    = PEND_NONE;
            reply_count = 0;
            due_words.push_back(w);
            readings++;
            return 1'b1;
         end

         // any command abandons a query in progress
         awaiting    = PEND_NONE;
         reply_count = 0;
         case (op)
            OP_SET_PAN: begin
               v = angle + pan_offset;
               if (v < 0) begin
                  v += PAN_FULL_TURN;
               end else if (v >= PAN_FULL_TURN) begin
                  v -= PAN_FULL_TURN;
               end
               v = clamp16(v);
               push_frame(CMD_SET_PAN, v[15:8], v[7:0]);
            end
            OP_SET_TILT: begin
               v = clamp16(TILT_ZERO - (angle + tilt_offset));
               push_frame(CMD_SET_TILT, v[15:8], v[7:0]);
            end
            OP_QUERY_PAN: begin
               awaiting = PEND_PAN;
               push_frame(CMD_QUERY_PAN, 8'h00, 8'h00);
            end
            OP_QUERY_TILT: begin
               awaiting = PEND_TILT;
               push_frame(CMD_QUERY_TILT, 8'h00, 8'h00);
            end
            OP_PRESET_GO: begin
               push_frame(CMD_PRESET_GO, 8'h00, preset);
            end
            OP_PRESET_SET: begin
               push_frame(CMD_PRESET_SET, 8'h00, preset);
            end
            default: begin
               push_frame(CMD_PRESET_CLR, 8'h00, preset);
            end
         endcase
         return 1'b1;
      endfunction

      function void check_word(logic [1:0] kind, logic [7:0] data, logic last,
                               logic signed [READING_W-1:0] reading);
         framer_word_type w;
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word kind %0d byte %02h last %0b reading %0d",
                     $time, kind, data, last, reading);
            errors++;
            return;
         end
         w = due_words.pop_front();
         if (kind !== w.kind || data !== w.data || last !== w.last || reading !== w.reading) begin
            $display("%0t: expected kind %0d byte %02h last %0b reading %0d",
                     $time, w.kind, w.data, w.last, w.reading);
            $display("%0t:   actual kind %0d byte %02h last %0b reading %0d",
                     $time, kind, data, last, reading);
            errors++;
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/tb_ptz_pelco_command_framer_top.sv -----
module tb_ptz_pelco_command_framer_top;

   import pcf_pkg::*;
   import pcf_check_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // angle_centi[16:0], preset_number[24:17], reply_byte[32:25], zero pad
   logic [REQ_TDATA_W-1:0] req_tdata;
   // operation[2:0]
   logic [2:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // send_byte[7:0], reading_centi[25:8], zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // result_kind[1:0]
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   ptz_frame_ledger ledger;

   // calm: both sides run back to back, no gaps and no stalls
   bit calm;
   int words_taken;
   int settings_used;

   ptz_pelco_command_framer_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop: far beyond the slowest legal run with every stall at its longest.
   initial begin
      #8000000;
      $display("tb_ptz_pelco_command_framer_top NOT OK");
      $finish;
   end

   function automatic int draw_gap();
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Mostly angles within one turn either way; now and then anything the field holds.
   function automatic int rand_angle();
      if ($urandom_range(0, 3) == 0) begin
         return int'($urandom_range(0, 131071)) - 65536;
      end
      return int'($urandom_range(0, 72000)) - 36000;
   endfunction

   // Lean on the byte extremes so reading corners come up often.
   function automatic int rand_byte();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Present one word after a random gap and hold it until the block takes it.
   // Keep tvalid high across back-to-back words: lower it only when a gap follows.
   task automatic send_word(input op_type op, input int angle, input int preset, input int rbyte);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-33){1'b0}}, rbyte[7:0], preset[7:0], angle[ANGLE_W-1:0]};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (ledger.take_request(op, angle, preset[7:0], rbyte[7:0])) begin
         words_taken++;
      end
   endtask

   // Drain: drop tvalid, wait for every expected word, then allow for a reply
   // byte that is still being absorbed and yields nothing.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write both offsets on consecutive edges; csr_we stays high across the pair.
   task automatic set_offsets(input int pan, input int tilt);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_PAN_OFFSET;
      csr_wdata <= pan[CSR_DATA_W-1:0];
      @(posedge clock);
      ledger.set_offset(CSR_PAN_OFFSET, pan[CSR_DATA_W-1:0]);
      csr_index <= CSR_TILT_OFFSET;
      csr_wdata <= tilt[CSR_DATA_W-1:0];
      @(posedge clock);
      ledger.set_offset(CSR_TILT_OFFSET, tilt[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Plain commands and query-and-reply exchanges with random content, the
   // exchanges mostly complete and now and then cut short by a command; also stray reply bytes.
   task automatic random_phase(input int target);
      int start;
      int pick;
      int n;
      start = words_taken;
      while (words_taken - start < target) begin
         if ($urandom_range(0, 15) == 0) begin
            calm = ~calm;
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            send_word($urandom_range(0, 1) ? OP_QUERY_TILT : OP_QUERY_PAN,
                      rand_angle(), $urandom_range(0, 255), rand_byte());
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
            for (int k = 0; k < n; k++) begin
               send_word(OP_REPLY, rand_angle(), $urandom_range(0, 255), rand_byte());
            end
         end else if (pick < 9) begin
            send_word(op_type'($urandom_range(0, 6)), rand_angle(),
                      $urandom_range(0, 255), rand_byte());
         end else begin
            send_word(OP_REPLY, rand_angle(), $urandom_range(0, 255), rand_byte());
         end
      end
   endtask

   // Result side: stall for a random gap before each word, then
   // take it and check it against the oldest expected word.
   initial begin : rsp_side
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         ledger.check_word(rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[25:8]);
      end
   end

   initial begin : req_side
      int pan_choice  [4] = '{65535, -65536, 36000, -36000};
      int tilt_choice [4] = '{-16384, 16383, -9000, 9000};
      ledger        = new();
      calm          = 1'b0;
      words_taken   = 0;
      settings_used = 1;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_PAN_OFFSET;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_SET_PAN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Offsets at reset: pan wrap in both directions and clamping of both axes.
      send_word(OP_SET_PAN, 0, 0, 0);
      send_word(OP_SET_PAN, 36000, 0, 0);
      send_word(OP_SET_PAN, -1, 0, 0);
      send_word(OP_SET_PAN, -65536, 0, 0);
      send_word(OP_SET_PAN, 65535, 0, 0);
      send_word(OP_SET_TILT, -65536, 0, 0);
      send_word(OP_SET_TILT, 65535, 0, 0);

      // Full pan query with the largest raw value in reply bytes four and five.
      send_word(OP_QUERY_PAN, 0, 0, 0);
      for (int k = 0; k < FRAME_BYTES; k++) begin
         send_word(OP_REPLY, 0, 0, (k == REPLY_HIGH_IDX || k == REPLY_LOW_IDX) ? 255 : k);
      end

      // Tilt query abandoned part-way by a preset command; the byte after is dropped.
      send_word(OP_QUERY_TILT, 0, 0, 0);
      send_word(OP_REPLY, 0, 0, 255);
      send_word(OP_REPLY, 0, 0, 0);
      send_word(OP_PRESET_SET, 0, 255, 0);
      send_word(OP_REPLY, 0, 0, 170);
      send_word(OP_PRESET_GO, 0, 0, 0);
      send_word(OP_PRESET_CLR, 0, 170, 0);

      // Offsets at their widest, then one turn and 9000, then random; a random phase for each.
      for (int phase = 0; phase < 5; phase++) begin
         if (phase < 4) begin
            set_offsets(pan_choice[phase], tilt_choice[phase]);
         end else begin
            set_offsets(int'($urandom_range(0, 72000)) - 36000,
                        int'($urandom_range(0, 18000)) - 9000);
         end
         if (phase == 0) begin
            send_word(OP_SET_PAN, 65535, 0, 0);
            send_word(OP_SET_TILT, -65536, 0, 0);
         end
         random_phase(30);
      end

      settle();
      $display("covered %0d request words: %0d frames and %0d readings over %0d offset settings",
               words_taken, ledger.frames, ledger.readings, settings_used);
      if (ledger.errors == 0) begin
         $display("tb_ptz_pelco_command_framer_top OK");
      end else begin
         $display("tb_ptz_pelco_command_framer_top NOT OK");
      end
      $finish;
   end

endmodule
